[src/asfc_pkg.sv]
// ----------------------------------------------------------------------------
// asfc_pkg
// shared types, codes and helpers of the audio sample format converter
// ----------------------------------------------------------------------------
package asfc_pkg;

  localparam logic [1:0] FMT_I16 = 2'd0;
  localparam logic [1:0] FMT_F32 = 2'd1;
  localparam logic [1:0] FMT_I32 = 2'd2;
  localparam logic [1:0] FMT_I24 = 2'd3;

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_I2I  = 2'd1;
  localparam logic [1:0] MODE_I2F  = 2'd2;
  localparam logic [1:0] MODE_F2I  = 2'd3;

  localparam logic [1:0] CFG_SOURCE = 2'd0;
  localparam logic [1:0] CFG_TARGET = 2'd1;

  localparam int unsigned NumStages = 6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic        last;
    logic        sign;
    logic        zero;
    logic [7:0]  fexp;
    logic [31:0] val;
  } s1_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic        last;
    logic        sign;
    logic        zero;
    logic [7:0]  fexp;
    logic [5:0]  lz;
    logic [31:0] val;
    logic [47:0] prod;
  } s2_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic        last;
    logic        sign;
    logic        zero;
    logic [5:0]  lz;
    logic [31:0] val;
    logic [23:0] kept;
    logic        g;
    logic        st;
    logic [9:0]  ee;
  } s3_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic        last;
    logic        sign;
    logic        zero;
    logic [5:0]  lz;
    logic [31:0] val;
    logic [47:0] wide;
    logic [24:0] rr;
    logic [9:0]  ee;
  } s4_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  dst;
    logic        last;
    logic        sign;
    logic        zero;
    logic [31:0] val;
    logic [26:0] qn;
    logic        stk;
    logic [7:0]  bexp;
    logic [32:0] mag;
  } s5_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } res_t;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       done;
    n    = 6'd32;
    done = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!done && v[i]) begin
        n    = 6'(31 - i);
        done = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[src/asfc_if.sv]
// ----------------------------------------------------------------------------
// asfc interfaces
// sample request channels and the configuration write channel
// ----------------------------------------------------------------------------
interface asfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_in;
  logic        last_in;
  modport source(output valid, sample_in, last_in, input ready);
  modport sink(input valid, sample_in, last_in, output ready);
endinterface

interface asfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_out;
  logic        last_out;
  modport source(output valid, sample_out, last_out, input ready);
  modport sink(input valid, sample_out, last_out, output ready);
endinterface

interface asfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/asfc_decode.sv]
// ----------------------------------------------------------------------------
// asfc_decode
// stages 1-2: format decode, unpack, leading zero count, scale multiply
// ----------------------------------------------------------------------------
module asfc_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           src_fmt_i,
  input  logic [1:0]           dst_fmt_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [31:0]          sample_i,
  input  logic                 last_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output asfc_pkg::s2_t        data_o
);
  import asfc_pkg::*;

  logic  va_q, vb_q, en_a, en_b;
  s1_t   a_d, a_q;
  s2_t   b_d, b_q;
  logic [31:0] al, n;
  logic [22:0] k;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vb_q;
  assign data_o  = b_q;

  always_comb begin
    a_d      = '0;
    a_d.src  = src_fmt_i;
    a_d.dst  = dst_fmt_i;
    a_d.last = last_i;
    if (src_fmt_i == FMT_F32 && dst_fmt_i == FMT_F32) a_d.mode = MODE_COPY;
    else if (src_fmt_i == FMT_F32)                    a_d.mode = MODE_F2I;
    else if (dst_fmt_i == FMT_F32)                    a_d.mode = MODE_I2F;
    else                                              a_d.mode = MODE_I2I;

    case (src_fmt_i)
      FMT_I16: al = {sample_i[15:0], 16'd0};
      FMT_I24: al = {sample_i[23:0], 8'd0};
      default: al = sample_i;
    endcase
    case (src_fmt_i)
      FMT_I16: n = {{16{sample_i[15]}}, sample_i[15:0]};
      FMT_I24: n = {{8{sample_i[23]}}, sample_i[23:0]};
      default: n = sample_i;
    endcase

    case (a_d.mode)
      MODE_COPY: a_d.val = sample_i;
      MODE_I2I: begin
        case (dst_fmt_i)
          FMT_I16: a_d.val = {16'd0, al[31:16]};
          FMT_I24: a_d.val = {8'd0, al[31:8]};
          default: a_d.val = al;
        endcase
      end
      MODE_I2F: begin
        a_d.sign = n[31];
        a_d.val  = n[31] ? (~n + 32'd1) : n;
        a_d.zero = (n == 32'd0);
      end
      default: begin
        a_d.sign = sample_i[31];
        if (sample_i[30:23] == 8'hff && sample_i[22:0] != 23'd0) begin
          a_d.zero = 1'b1;
        end else if (sample_i[30:23] >= 8'd127) begin
          a_d.fexp = 8'd127;
          a_d.val  = 32'h0080_0000;
        end else if (sample_i[30:23] == 8'd0) begin
          a_d.zero = 1'b1;
        end else begin
          a_d.fexp = sample_i[30:23];
          a_d.val  = {8'd0, 1'b1, sample_i[22:0]};
        end
      end
    endcase
  end

  always_comb begin
    case (a_q.dst)
      FMT_I16: k = 23'd32767;
      FMT_I24: k = 23'd8388607;
      default: k = 23'd1;
    endcase
    b_d.mode = a_q.mode;
    b_d.src  = a_q.src;
    b_d.dst  = a_q.dst;
    b_d.last = a_q.last;
    b_d.sign = a_q.sign;
    b_d.zero = a_q.zero;
    b_d.fexp = a_q.fexp;
    b_d.val  = a_q.val;
    b_d.lz   = lzc32(a_q.val);
    b_d.prod = {24'd0, a_q.val[23:0]} * {25'd0, k};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) a_q <= a_d;
    if (en_b && va_q)    b_q <= b_d;
  end

endmodule

[src/asfc_align.sv]
// ----------------------------------------------------------------------------
// asfc_align
// stages 3-4: normalize shift, float to int rounding, reciprocal estimate
// ----------------------------------------------------------------------------
module asfc_align (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  asfc_pkg::s2_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output asfc_pkg::s4_t data_o
);
  import asfc_pkg::*;

  logic  va_q, vb_q, en_a, en_b;
  s3_t   a_d, a_q;
  s4_t   b_d, b_q;
  logic [5:0]  base, lead;
  logic [4:0]  sh;
  logic [47:0] lo;
  logic [26:0] a0;
  logic [47:0] p;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vb_q;
  assign data_o  = b_q;

  always_comb begin
    case (data_i.dst)
      FMT_I16: base = 6'd37;
      FMT_I24: base = 6'd45;
      default: base = 6'd23;
    endcase
    lead = data_i.prod[base + 6'd1] ? base + 6'd1 : base;
    sh   = 5'(lead - 6'd23);
    lo   = data_i.prod << (6'd48 - {1'b0, sh});

    a_d.mode = data_i.mode;
    a_d.src  = data_i.src;
    a_d.dst  = data_i.dst;
    a_d.last = data_i.last;
    a_d.sign = data_i.sign;
    a_d.zero = data_i.zero;
    a_d.lz   = data_i.lz;
    a_d.val  = (data_i.mode == MODE_I2F) ? (data_i.val << data_i.lz) : data_i.val;
    a_d.kept = 24'(data_i.prod >> sh);
    a_d.g    = lo[47];
    a_d.st   = |lo[46:0];
    a_d.ee   = {2'b00, data_i.fexp} - 10'd150 + {5'd0, sh}
             + ((data_i.dst == FMT_I32) ? 10'd31 : 10'd0);
  end

  always_comb begin
    a0 = {1'b0, a_q.val[31:16], 10'd0} + {16'd0, a_q.val[31:21]};
    p  = {1'b0, a_q.val[31:8], 23'd0} + {24'd0, a_q.val[31:8]};
    b_d.mode = a_q.mode;
    b_d.src  = a_q.src;
    b_d.dst  = a_q.dst;
    b_d.last = a_q.last;
    b_d.sign = a_q.sign;
    b_d.zero = a_q.zero;
    b_d.lz   = a_q.lz;
    b_d.val  = a_q.val;
    b_d.wide = (a_q.src == FMT_I16) ? {21'd0, a0} : p;
    b_d.rr   = {1'b0, a_q.kept} + {24'd0, a_q.g & (a_q.st | a_q.kept[0])};
    b_d.ee   = a_q.ee;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) a_q <= a_d;
    if (en_b && va_q)    b_q <= b_d;
  end

endmodule

[src/asfc_pack.sv]
// ----------------------------------------------------------------------------
// asfc_pack
// stages 5-6: quotient correction, integer scaling, rounding and packing
// ----------------------------------------------------------------------------
module asfc_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  asfc_pkg::s4_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output asfc_pkg::res_t data_o
);
  import asfc_pkg::*;

  logic  va_q, vb_q, en_a, en_b;
  s5_t   a_d, a_q;
  res_t  b_d, b_q;
  logic [16:0] r17;
  logic        ge;
  logic [26:0] q;
  logic [9:0]  nsh;
  logic [23:0] mant;
  logic [24:0] rnd;
  logic        gb, sb;
  logic [7:0]  ex;
  logic [31:0] sv;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vb_q;
  assign data_o  = b_q;

  always_comb begin
    r17 = data_i.wide[16:0] - {data_i.wide[1:0], 15'd0};
    ge  = (r17 >= 17'd32767);
    q   = ge ? (data_i.wide[26:0] + 27'd1) : data_i.wide[26:0];
    nsh = 10'd0 - data_i.ee;

    a_d      = '0;
    a_d.mode = data_i.mode;
    a_d.dst  = data_i.dst;
    a_d.last = data_i.last;
    a_d.sign = data_i.sign;
    a_d.zero = data_i.zero;
    a_d.val  = data_i.val;
    case (data_i.src)
      FMT_I16: begin
        a_d.stk = ge ? (r17 != 17'd32767) : (r17 != 17'd0);
        if (q[26]) begin
          a_d.qn   = q;
          a_d.bexp = 8'd144 - {2'b00, data_i.lz};
        end else begin
          a_d.qn   = {q[25:0], 1'b0};
          a_d.bexp = 8'd143 - {2'b00, data_i.lz};
        end
      end
      FMT_I24: begin
        if (data_i.wide[47]) begin
          a_d.qn   = data_i.wide[47:21];
          a_d.stk  = |data_i.wide[20:0];
          a_d.bexp = 8'd136 - {2'b00, data_i.lz};
        end else begin
          a_d.qn   = data_i.wide[46:20];
          a_d.stk  = |data_i.wide[19:0];
          a_d.bexp = 8'd135 - {2'b00, data_i.lz};
        end
      end
      default: begin
        a_d.qn   = data_i.val[31:5];
        a_d.stk  = |data_i.val[4:0];
        a_d.bexp = 8'd127 - {2'b00, data_i.lz};
      end
    endcase
    if (!data_i.ee[9])           a_d.mag = {8'd0, data_i.rr} << data_i.ee[3:0];
    else if (nsh > 10'd25)       a_d.mag = 33'd0;
    else                         a_d.mag = {8'd0, data_i.rr} >> nsh[4:0];
  end

  always_comb begin
    mant = a_q.qn[26:3];
    gb   = a_q.qn[2];
    sb   = a_q.qn[1] | a_q.qn[0] | a_q.stk;
    rnd  = {1'b0, mant} + {24'd0, gb & (sb | mant[0])};
    ex   = rnd[24] ? a_q.bexp + 8'd1 : a_q.bexp;
    sv   = a_q.sign ? (~a_q.mag[31:0] + 32'd1) : a_q.mag[31:0];
    b_d.last = a_q.last;
    case (a_q.mode)
      MODE_I2F: b_d.sample = a_q.zero ? 32'd0 : {a_q.sign, ex, rnd[22:0]};
      MODE_F2I: begin
        if (a_q.zero) begin
          b_d.sample = 32'd0;
        end else begin
          case (a_q.dst)
            FMT_I16: b_d.sample = {16'd0, sv[15:0]};
            FMT_I24: b_d.sample = {8'd0, sv[23:0]};
            default: b_d.sample = (!a_q.sign && a_q.mag[32:31] != 2'b00)
                                  ? 32'h7fff_ffff : sv;
          endcase
        end
      end
      default: b_d.sample = a_q.val;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) a_q <= a_d;
    if (en_b && va_q)    b_q <= b_d;
  end

endmodule

[src/audio_sample_format_converter.sv]
// throughput: one sample per cycle while the output is not stalled, six-stage pipeline with per-stage valids
// stalls ripple back stage by stage, so bubbles are filled while a result waits
// reset clears all stage valids and sets both formats to int16
// ----------------------------------------------------------------------------
// audio_sample_format_converter
// pcm sample conversion between int16, int24, int32 and float32
// ----------------------------------------------------------------------------
module audio_sample_format_converter (
  input  logic     clk_i,
  input  logic     rst_ni,
  asfc_cfg_if.sink cfg_i,
  asfc_in_if.sink  in_i,
  asfc_out_if.source out_o
);
  import asfc_pkg::*;

  logic [1:0] src_fmt_q, dst_fmt_q;
  logic       v2, r2, v4, r4;
  s2_t        d2;
  s4_t        d4;
  res_t       d6;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FMT_I16;
      dst_fmt_q <= FMT_I16;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_SOURCE) src_fmt_q <= cfg_i.data;
      if (cfg_i.index == CFG_TARGET) dst_fmt_q <= cfg_i.data;
    end
  end

  asfc_decode u_decode (
    .clk_i, .rst_ni,
    .src_fmt_i (src_fmt_q),
    .dst_fmt_i (dst_fmt_q),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .sample_i  (in_i.sample_in),
    .last_i    (in_i.last_in),
    .valid_o   (v2),
    .ready_i   (r2),
    .data_o    (d2)
  );

  asfc_align u_align (
    .clk_i, .rst_ni,
    .valid_i (v2),
    .ready_o (r2),
    .data_i  (d2),
    .valid_o (v4),
    .ready_i (r4),
    .data_o  (d4)
  );

  asfc_pack u_pack (
    .clk_i, .rst_ni,
    .valid_i (v4),
    .ready_o (r4),
    .data_i  (d4),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (d6)
  );

  assign out_o.sample_out = d6.sample;
  assign out_o.last_out   = d6.last;

endmodule

[src/asfc_checker.sv]
// ----------------------------------------------------------------------------
// asfc_checker
// port-level checks of the format converter, bound to the top level
// ----------------------------------------------------------------------------
module asfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_sample_i
);
  import asfc_pkg::*;

  logic [3:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 4'd1;
    if (!in_acc && out_acc) cnt_d = cnt_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 4'd0;
    else         cnt_q <= cnt_d;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 4'd0)
    else $error("result without request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(NumStages))
    else $error("more requests in flight than stages");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output stall");

endmodule

bind audio_sample_format_converter asfc_checker u_asfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);
